// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define RFP_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hdl/rfp_pkg.sv -----
// ----------------------------------------------------------------------------
// rfp_pkg
// Types, fixed-point constants and rounding helper of the repeller field block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfp_pkg;

  localparam int DATA_W = 32;
  localparam int OUT_W  = 56;
  localparam int CFG_AW = 2;

  // internal ratios and weights are unsigned Q.28
  localparam int    QB    = 28;
  localparam int    RQW   = QB + 1;
  localparam longint QONE = 64'sd1 <<< QB;
  localparam longint Q3   = 3 * QONE;
  localparam longint Q6   = 6 * QONE;
  localparam longint Q8   = 8 * QONE;
  localparam longint Q12  = 12 * QONE;
  localparam longint QHALF = 64'sd1 <<< (QB - 1);

  localparam longint OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam longint OUT_MIN_MAG = 64'sd1 <<< (OUT_W - 1);

  typedef enum logic [CFG_AW-1:0] {
    REG_CUTOFF    = 2'd0,
    REG_BARRIER   = 2'd1,
    REG_BULGE_POS = 2'd2,
    REG_BULGE_PK  = 2'd3
  } cfg_reg_t;

  // product over 2^QB, rounded half away from zero
  function automatic logic signed [63:0] rnd_q(input logic signed [63:0] p);
    logic        neg;
    logic [63:0] m;
    neg = p[63];
    m   = neg ? (~p + 64'd1) : p;
    m   = (m + 64'(QHALF)) >> QB;
    return neg ? $signed(~m + 64'd1) : $signed(m);
  endfunction

endpackage

// ----- hdl/rfp_div.sv -----
// ----------------------------------------------------------------------------
// rfp_div
// Pipelined restoring divider, one quotient bit per stage, with sideband and
// trailing delay stages so that several dividers line up at a common depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfp_div #(
  parameter int DW  = 32,
  parameter int QW  = 29,
  parameter int LAT = 52,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem0,     // must be below divisor
  input  logic [QW-1:0] qd0,      // low dividend bits
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic [DW-1:0] rem_r  [LAT];
  logic [DW-1:0] div_r  [LAT];
  logic [QW-1:0] qd_r   [LAT];
  logic [SW-1:0] side_r [LAT];

  for (genvar i = 0; i < LAT; i++) begin : g_st
    logic [DW-1:0] rem_src, div_src, rem_nxt;
    logic [QW-1:0] qd_src, qd_nxt;
    logic [SW-1:0] side_src;

    if (i == 0) begin : g_first
      assign rem_src  = rem0;
      assign div_src  = divisor;
      assign qd_src   = qd0;
      assign side_src = side_in;
    end else begin : g_next
      assign rem_src  = rem_r[i-1];
      assign div_src  = div_r[i-1];
      assign qd_src   = qd_r[i-1];
      assign side_src = side_r[i-1];
    end

    if (i < QW) begin : g_div
      logic [DW:0] trial, sub;
      logic        ge;
      assign trial   = {rem_src, qd_src[QW-1]};
      assign ge      = trial >= {1'b0, div_src};
      assign sub     = trial - {1'b0, div_src};
      assign rem_nxt = ge ? sub[DW-1:0] : trial[DW-1:0];
      assign qd_nxt  = {qd_src[QW-2:0], ge};
    end else begin : g_hold
      assign rem_nxt = rem_src;
      assign qd_nxt  = qd_src;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        div_r[i]  <= div_src;
        qd_r[i]   <= qd_nxt;
        side_r[i] <= side_src;
      end
    end
  end

  assign quo      = qd_r[LAT-1];
  assign side_out = side_r[LAT-1];

endmodule

// ----- hdl/repeller_field_profile_top.sv -----
// ----------------------------------------------------------------------------
// repeller_field_profile_top
// Pipeline: one input stage, 32 + FRAC_BITS divider stages and 16 post stages
// from accepted height to result.
// Throughput: one height per cycle while the output is not stalled; the
// barrier divider's one-bit-per-stage pipeline sets the depth. Synchronous
// active-low reset zeroes config and valid bits and empties the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module repeller_field_profile_top
  import rfp_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_AW-1:0]        cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_height,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  out_field_value,
  output logic                     out_saturated
);

  localparam int BQW = DATA_W + FRAC_BITS;   // barrier quotient bits
  localparam int LAT = BQW;
  localparam int DFW = BQW + 2;
  localparam int HPW = DFW - DATA_W + RQW;
  localparam int RW  = (FRAC_BITS + 36 > OUT_W + 1) ? FRAC_BITS + 36 : OUT_W + 1;
  localparam int NP  = 15;
  localparam int NV  = 1 + LAT + NP;
  localparam int HI_SH = DATA_W - QB;

  typedef struct packed {
    logic                     zero;
    logic                     ben;
    logic                     bneg;
    logic                     sge;
    logic                     neg;
    logic signed [DATA_W-1:0] d;
    logic [RQW-1:0]           r;
    logic [RQW-1:0]           w;
    logic [BQW-1:0]           bm;
  } carry_t;

  // configuration
  logic signed [DATA_W-1:0] cutoff_r, barrier_r, bulge_pos_r, bulge_pk_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r    <= '0;
      barrier_r   <= '0;
      bulge_pos_r <= '0;
      bulge_pk_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CUTOFF:    cutoff_r    <= cfg_data;
        REG_BARRIER:   barrier_r   <= cfg_data;
        REG_BULGE_POS: bulge_pos_r <= cfg_data;
        REG_BULGE_PK:  bulge_pk_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance: the whole pipe moves unless the output register is held
  logic          adv;
  logic [NV-1:0] vld_r;
  logic          out_valid_r, out_sat_r;
  logic signed [OUT_W-1:0] out_field_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NV-2:0], in_valid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  // input stage: clamp, cut-off test, dividend setup
  logic [DATA_W-1:0] zc, babs;
  logic              zero_nxt, ben_nxt;
  logic [BQW-1:0]    bq_nxt;

  assign zero_nxt = (cutoff_r <= 0) || (in_height >= cutoff_r);
  assign zc       = (in_height < 32'sd1) ? 32'd1 : in_height;
  assign ben_nxt  = (bulge_pos_r > 0) && ({1'b0, zc} < {bulge_pos_r, 1'b0});
  assign babs     = barrier_r[DATA_W-1] ? (~barrier_r + 32'd1) : barrier_r;
  assign bq_nxt   = {babs, {FRAC_BITS{1'b0}}} + BQW'(zc >> 1);

  logic [DATA_W-1:0]        pre_z_r, pre_a_r, pre_c_r;
  logic signed [DATA_W-1:0] pre_d_r;
  logic [BQW-1:0]           pre_bq_r;
  logic                     pre_zero_r, pre_ben_r, pre_bneg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_z_r    <= zc;
      pre_a_r    <= cutoff_r;
      pre_c_r    <= bulge_pos_r;
      pre_d_r    <= bulge_pk_r;
      pre_bq_r   <= bq_nxt;
      pre_zero_r <= zero_nxt;
      pre_ben_r  <= ben_nxt;
      pre_bneg_r <= barrier_r[DATA_W-1];
    end
  end

  // three dividers in parallel: z/C, z/A and |B|/z
  logic [RQW-1:0]    rq, sq;
  logic [BQW-1:0]    bm;
  logic [DATA_W:0]   r_side;
  logic              zero_side, bneg_side;

  rfp_div #(.DW(DATA_W), .QW(RQW), .LAT(LAT), .SW(DATA_W + 1)) u_div_r (
    .clk      (clk),
    .en       (adv),
    .rem0     (pre_z_r >> 1),
    .qd0      ({pre_z_r[0], {QB{1'b0}}}),
    .divisor  (pre_c_r),
    .side_in  ({pre_ben_r, pre_d_r}),
    .quo      (rq),
    .side_out (r_side)
  );

  rfp_div #(.DW(DATA_W), .QW(RQW), .LAT(LAT), .SW(1)) u_div_s (
    .clk      (clk),
    .en       (adv),
    .rem0     (pre_z_r >> 1),
    .qd0      ({pre_z_r[0], {QB{1'b0}}}),
    .divisor  (pre_a_r),
    .side_in  (pre_zero_r),
    .quo      (sq),
    .side_out (zero_side)
  );

  rfp_div #(.DW(DATA_W), .QW(BQW), .LAT(LAT), .SW(1)) u_div_b (
    .clk      (clk),
    .en       (adv),
    .rem0     ({DATA_W{1'b0}}),
    .qd0      (pre_bq_r),
    .divisor  (pre_z_r),
    .side_in  (pre_bneg_r),
    .quo      (bm),
    .side_out (bneg_side)
  );

  // post pipeline: carried fields
  carry_t c0;
  carry_t cr_r   [1:NP];
  carry_t cr_nxt [1:NP];
  logic [RQW-1:0] w_nxt;
  logic           neg_nxt;

  always_comb begin
    c0.zero = zero_side;
    c0.ben  = r_side[DATA_W];
    c0.bneg = bneg_side;
    c0.sge  = sq[QB];
    c0.neg  = 1'b0;
    c0.d    = $signed(r_side[DATA_W-1:0]);
    c0.r    = rq;
    c0.w    = '0;
    c0.bm   = bm;
    cr_nxt[1] = c0;
    for (int p = 2; p <= NP; p++) begin
      cr_nxt[p] = cr_r[p-1];
    end
    cr_nxt[4].w    = w_nxt;
    cr_nxt[13].neg = neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 1; p <= NP; p++) begin
        cr_r[p] <= cr_nxt[p];
      end
    end
  end

  // P1: (6 - r) r and s^2
  logic signed [63:0] k1_64;
  logic [59:0]        m1_nxt, m1_r;
  logic [57:0]        sm1_nxt, sm1_r;
  logic [RQW-1:0]     s1_r;

  assign k1_64   = Q6 - $signed({35'd0, rq});
  assign m1_nxt  = k1_64[30:0] * rq;
  assign sm1_nxt = sq * sq;

  // P2: subtract 12, round s^2, form 3 - 2s
  logic signed [63:0] t1_64, ss_64, k_64;
  logic signed [32:0] t1_r;
  logic [RQW-1:0]     ss_r;
  logic [RQW:0]       k_r;

  assign t1_64 = rnd_q({4'd0, m1_r}) - Q12;
  assign ss_64 = rnd_q({6'd0, sm1_r});
  assign k_64  = Q3 - $signed({34'd0, s1_r, 1'b0});

  // P3
  logic signed [62:0] m2_nxt, m2_r;
  logic [58:0]        sm2_nxt, sm2_r;

  assign m2_nxt  = t1_r * $signed({1'b0, cr_r[2].r});
  assign sm2_nxt = ss_r * k_r;

  // P4: add 8, fade weight
  logic signed [63:0] t2_64, e_64, wd_64;
  logic signed [33:0] t2_r;

  assign t2_64 = rnd_q(64'(m2_r)) + Q8;
  assign e_64  = rnd_q({5'd0, sm2_r});
  assign wd_64 = QONE - e_64;
  assign w_nxt = (cr_r[3].sge || e_64 >= QONE) ? '0 : wd_64[RQW-1:0];

  // P5..P10: three more factors of r
  logic signed [63:0] m3_nxt, m3_r;
  logic signed [63:0] t3_64, t4_64, b_64;
  logic signed [31:0] t3_r, t4_r, bump_r;
  logic signed [61:0] m4_nxt, m4_r, m5_nxt, m5_r;

  assign m3_nxt = t2_r * $signed({1'b0, cr_r[4].r});
  assign t3_64  = rnd_q(m3_r);
  assign m4_nxt = t3_r * $signed({1'b0, cr_r[6].r});
  assign t4_64  = rnd_q(64'(m4_r));
  assign m5_nxt = t4_r * $signed({1'b0, cr_r[8].r});
  assign b_64   = rnd_q(64'(m5_r));

  // P11: D * bump, P12: bulge - barrier
  logic signed [63:0]    m6_nxt, m6_r, bul_64;
  logic signed [DFW-1:0] bul_d, bm_ext, diff_nxt, diff_r;

  assign m6_nxt   = cr_r[10].d * bump_r;
  assign bul_64   = rnd_q(m6_r);
  assign bul_d    = bul_64[DFW-1:0];
  assign bm_ext   = $signed({2'b00, cr_r[11].bm});
  assign diff_nxt = cr_r[11].bneg ? (bul_d + bm_ext) : (bul_d - bm_ext);

  // P13: magnitude, P14: split products, P15: recombine
  logic [DFW-1:0] mag_nxt, mag_r;
  logic [HPW-1:0] hp_nxt, hp_r;
  logic [60:0]    lp_nxt, lp_r;
  logic [RW-1:0]  res_nxt, res_r;

  assign neg_nxt = diff_r[DFW-1];
  assign mag_nxt = neg_nxt ? (~diff_r + 1'b1) : diff_r;
  assign hp_nxt  = mag_r[DFW-1:DATA_W] * cr_r[13].w;
  assign lp_nxt  = mag_r[DATA_W-1:0] * cr_r[13].w;
  assign res_nxt = (RW'(hp_r) << HI_SH) + RW'((lp_r + 61'(QHALF)) >> QB);

  // P16: sign, saturation
  logic                    sat_nxt;
  logic signed [OUT_W-1:0] fv_nxt;

  always_comb begin
    sat_nxt = 1'b0;
    fv_nxt  = '0;
    if (!cr_r[15].zero) begin
      if (!cr_r[15].neg) begin
        sat_nxt = res_r > RW'(OUT_MAX);
        fv_nxt  = sat_nxt ? OUT_W'(OUT_MAX) : $signed(res_r[OUT_W-1:0]);
      end else begin
        sat_nxt = res_r > RW'(OUT_MIN_MAG);
        fv_nxt  = sat_nxt ? OUT_W'(OUT_MIN_MAG) : $signed(~res_r[OUT_W-1:0] + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r        <= m1_nxt;
      sm1_r       <= sm1_nxt;
      s1_r        <= sq;
      t1_r        <= t1_64[32:0];
      ss_r        <= ss_64[RQW-1:0];
      k_r         <= k_64[RQW:0];
      m2_r        <= m2_nxt;
      sm2_r       <= sm2_nxt;
      t2_r        <= t2_64[33:0];
      m3_r        <= m3_nxt;
      t3_r        <= t3_64[31:0];
      m4_r        <= m4_nxt;
      t4_r        <= t4_64[31:0];
      m5_r        <= m5_nxt;
      bump_r      <= (cr_r[9].ben && cr_r[9].r != '0) ? b_64[31:0] : '0;
      m6_r        <= m6_nxt;
      diff_r      <= diff_nxt;
      mag_r       <= mag_nxt;
      hp_r        <= hp_nxt;
      lp_r        <= lp_nxt;
      res_r       <= res_nxt;
      out_field_r <= fv_nxt;
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_field_value = out_field_r;
  assign out_saturated   = out_sat_r;

  // assertions
  `RFP_ASSERT(a_sat_at_bound, (out_valid_r && out_sat_r) |-> (out_field_r == OUT_W'(OUT_MAX) || out_field_r == OUT_W'(OUT_MIN_MAG)), "saturated result not at a range bound")
  `RFP_ASSERT(a_hold_on_stall, (!adv) |=> $stable(vld_r), "pipeline valid bits moved while stalled")
  `RFP_ASSERT_NEVER(a_weight_range, vld_r[LAT+5] && (cr_r[5].w > QONE[RQW-1:0]), "fade weight above one")

endmodule

// ----- sim/rfp_field_checker.sv -----
// ----------------------------------------------------------------------------
// rfp_field_checker
// Watches the config, height and field channels of the repeller field block,
// keeps shadow registers, predicts one field result per accepted height and
// compares every accepted result in order against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfp_field_checker
  import rfp_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_AW-1:0]        cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_height,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [OUT_W-1:0]  out_field_value,
  input  logic                     out_saturated,
  output int                       errors,
  output int                       pending
);

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             sat;
  } field_res_t;

  logic signed [DATA_W-1:0] sh_cutoff, sh_barrier, sh_bulge_pos, sh_bulge_pk;
  field_res_t               field_q[$];

  assign pending = field_q.size();

  // product over 2^28, rounded half away from zero
  function automatic longint mul_round(input longint x, input longint y);
    longint      p;
    logic [63:0] m;
    p = x * y;
    m = (p < 0) ? 64'(-p) : 64'(p);
    m = (m + 64'(QHALF)) >> QB;
    return (p < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic field_res_t predict_field(input logic signed [DATA_W-1:0] zin);
    longint      a, b, c, d, z, bulge, barrier, diff, s, e, w, res, r, t;
    logic [63:0] bm, m, hi, lo, wu, rr;
    field_res_t  o;
    a = sh_cutoff;
    b = sh_barrier;
    c = sh_bulge_pos;
    d = sh_bulge_pk;
    z = zin;
    o = '0;
    bulge = 0;
    if (a <= 0 || z >= a) return o;
    if (z < 1) z = 1;

    if (c > 0 && z < 2 * c) begin
      r = (z <<< QB) / c;
      if (r > 0 && r < 2 * QONE) begin
        t = mul_round(Q6 - r, r) - Q12;
        t = mul_round(t, r) + Q8;
        t = mul_round(t, r);
        t = mul_round(t, r);
        t = mul_round(t, r);
      end else begin
        t = 0;
      end
      bulge = mul_round(d, t);
    end

    bm = (b < 0) ? 64'(-b) : 64'(b);
    bm = ((bm << FRAC_BITS) + (64'(z) >> 1)) / 64'(z);
    barrier = (b < 0) ? -longint'(bm) : longint'(bm);
    diff = bulge - barrier;

    s = (z <<< QB) / a;
    if (s >= QONE) e = QONE;
    else e = mul_round(mul_round(s, s), Q3 - 2 * s);
    w = QONE - e;
    if (w < 0) w = 0;
    if (w > QONE) w = QONE;

    // 64-bit safe scaling of diff by the fade weight
    m  = (diff < 0) ? 64'(-diff) : 64'(diff);
    hi = m >> 32;
    lo = m & 64'hFFFF_FFFF;
    wu = 64'(w);
    rr = ((hi * wu) << (32 - QB)) + ((lo * wu + 64'(QHALF)) >> QB);
    res = (diff < 0) ? -longint'(rr) : longint'(rr);

    if (res > OUT_MAX) begin
      res = OUT_MAX;
      o.sat = 1'b1;
    end
    if (res < -OUT_MIN_MAG) begin
      res = -OUT_MIN_MAG;
      o.sat = 1'b1;
    end
    o.value = res[OUT_W-1:0];
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    field_res_t exp_r;
    if (!rst_n) begin
      sh_cutoff    <= '0;
      sh_barrier   <= '0;
      sh_bulge_pos <= '0;
      sh_bulge_pk  <= '0;
      field_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (field_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", out_field_value));
        end else begin
          exp_r = field_q.pop_front();
          if (out_field_value !== $signed(exp_r.value))
            report_mismatch($sformatf("field_value got %0d want %0d",
                                      out_field_value, $signed(exp_r.value)));
          if (out_saturated !== exp_r.sat)
            report_mismatch($sformatf("saturated got %0b want %0b",
                                      out_saturated, exp_r.sat));
        end
      end
      if (in_valid && !in_stall) field_q.push_back(predict_field(in_height));
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CUTOFF:    sh_cutoff    <= cfg_data;
          REG_BARRIER:   sh_barrier   <= cfg_data;
          REG_BULGE_POS: sh_bulge_pos <= cfg_data;
          REG_BULGE_PK:  sh_bulge_pk  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sim/repeller_field_profile_top_tb.sv -----
// ----------------------------------------------------------------------------
// repeller_field_profile_top_tb
// Drives config settings and height transactions into the repeller field
// block under varied idle/stall mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module repeller_field_profile_top_tb;
  import rfp_pkg::*;

  localparam int  DRAIN_CYCLES = 120;
  localparam int  CYCLE_LIMIT  = 600000;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_AW-1:0]        cfg_index;
  logic [DATA_W-1:0]        cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_height;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [OUT_W-1:0]  out_field_value;
  logic                     out_saturated;
  int                       errors;
  int                       pending;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int cycle_cnt;
  logic signed [DATA_W-1:0] cur_a, cur_c;

  repeller_field_profile_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_height(in_height),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_field_value(out_field_value), .out_saturated(out_saturated)
  );

  rfp_field_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_height(in_height),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_field_value(out_field_value), .out_saturated(out_saturated),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver: long hold-off takes priority over random stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic cfg_write(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_CUTOFF) cur_a = val;
    if (idx == REG_BULGE_POS) cur_c = val;
  endtask

  task automatic set_field(input logic [31:0] a, b, c, d);
    cfg_write(REG_CUTOFF, a);
    cfg_write(REG_BARRIER, b);
    cfg_write(REG_BULGE_POS, c);
    cfg_write(REG_BULGE_PK, d);
  endtask

  task automatic send_height(input logic [31:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_height <= h;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // heights biased toward the interesting region below the cut-off
  function automatic logic [31:0] pick_height();
    longint a, c, v;
    a = cur_a;
    c = cur_c;
    case ($urandom_range(9))
      0, 1:    v = $urandom;
      2:       v = $urandom_range(64);
      3:       v = -longint'($urandom_range(64));
      4, 5, 6: v = (a > 0) ? longint'($urandom_range(32'(a))) : $urandom;
      7:       v = a + longint'($urandom_range(4)) - 2;
      8:       v = (c > 0) ? longint'($urandom_range(32'(c > 32'h3FFF_FFFF ?
                   64'h7FFF_FFFF : 2 * c))) : $urandom;
      default: v = 2 * c + longint'($urandom_range(4)) - 2;
    endcase
    return 32'(v);
  endfunction

  task automatic random_run(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_height(pick_height());
    drain();
  endtask

  task automatic random_config;
    logic [31:0] a;
    a = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0800_0000);
    set_field(a, $urandom_range(1) ? $urandom : $urandom_range(32'h0010_0000),
              $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0400_0000),
              $urandom);
  endtask

  initial begin
    logic [31:0] dir_h[$];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_height = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    cur_a = '0;
    cur_c = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // cut-off still zero after reset: everything reads zero
    send_height(32'h0000_1000);
    send_height(32'h8000_0000);
    drain();

    set_field(32'h0040_0000, 32'h0001_0000, 32'h0010_0000, 32'h0020_0000);
    dir_h = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h003F_FFFF, 32'h0040_0000, 32'h0040_0001, 32'h0010_0000,
              32'h001F_FFFF, 32'h0020_0000, 32'h0008_0000, 32'h0030_0000};
    foreach (dir_h[i]) send_height(dir_h[i]);
    drain();

    // extreme magnitudes: tiny ratio z/C, most negative barrier
    set_field(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    dir_h = '{32'h1, 32'h0, 32'h8000_0000, 32'h7FFF_FFFE, 32'h4000_0000,
              32'h0000_0010};
    foreach (dir_h[i]) send_height(dir_h[i]);
    drain();

    // one-LSB cut-off, bulge disabled by negative position
    set_field(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_height(32'h0);
    send_height(32'h1);
    send_height(32'hFFFF_FFF0);
    drain();

    // negative cut-off disables the field
    set_field(32'hFFFF_FFFB, $urandom, $urandom, $urandom);
    send_height(32'h8000_0000);
    send_height(32'h0000_0005);
    drain();

    set_field(32'h0100_0000, 32'h0000_8000, 32'h0020_0000, 32'hFFE0_0000);
    random_run(250, 0, 0);
    random_config();
    random_run(250, 49, 0);
    random_config();
    random_run(250, 0, 49);
    random_config();
    random_run(250, 30, 30);

    // long receiver hold-off while the sender keeps offering
    set_field(32'h0400_0000, 32'hFFF0_0000, 32'h0080_0000, 32'h0100_0000);
    hold_cycles = 400;
    random_run(200, 0, 0);

    set_field(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000);
    random_run(150, 30, 30);
    repeat (3) begin
      random_config();
      random_run(170, $urandom_range(1) ? 49 : 0, $urandom_range(1) ? 49 : 0);
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
